@@ rtl/izcl_pkg.sv @@
// ----------------------------------------------------------------------------
// izcl_pkg
// Shared types and constants for the interface zero-crossing locator.
// ----------------------------------------------------------------------------
`default_nettype none

package izcl_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int CFG_W         = 10;
	localparam int CFG_IDX_W     = 1;
	localparam int CNT_W         = 10;
	localparam int POS_W         = 18;
	localparam int MAX_LEN_DEF   = 1024;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [CFG_W-1:0] FIRST_PAIR_RST = CFG_W'(10);
	localparam logic [CFG_W-1:0] LAST_PAIR_RST  = CFG_W'(1012);
	localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_PAIR,
		REG_LAST_PAIR
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INTERP,
		ST_MEAN_GO,
		ST_MEAN,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} in_beat_t;

	typedef struct packed {
		logic [POS_W-1:0] rise_position;
		logic [POS_W-1:0] fall_position;
		logic [CNT_W-1:0] rise_count;
		logic [CNT_W-1:0] fall_count;
		logic             rise_found;
		logic             fall_found;
	} out_beat_t;

endpackage

`default_nettype wire

@@ rtl/izcl_sdiv.sv @@
// ----------------------------------------------------------------------------
// izcl_sdiv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module izcl_sdiv #(
	parameter int DVD_W = 8,
	parameter int DVS_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVS_W-1:0] rem_init,   // must be below divisor
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DVD_W-1:0]      quot
);

	localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;   // dividend bits out at the top, quotient bits in at the bottom
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   sh;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_n;

	always_comb begin
		sh    = {rem_q, dvd_q[DVD_W-1]};
		diff  = sh - {1'b0, dvs_q};
		ge    = (sh >= {1'b0, dvs_q});
		rem_n = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = dvd_q;

endmodule

`default_nettype wire

@@ rtl/interface_zero_crossing_locator.sv @@
// ----------------------------------------------------------------------------
// interface_zero_crossing_locator
// Finds rising and falling zero crossings in a sample column and reports
// their mean interpolated positions at the end of the column.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one signed sample per beat, last marks the end of a column.
//   out channel : one beat per column, sent after the beat marked last, with
//                 both mean positions (FRAC_BITS fraction bits), counts and
//                 found flags.
//   cfg port    : first_pair / last_pair window, written while idle.
// Input flow: a sample that forms no crossing and is not marked last leaves
//   the block ready for the next one. A crossing holds off the input while
//   the bit-serial interpolation divider works (one fraction bit per cycle).
// Result: after the last beat, and after the interpolation if the final
//   pair crosses, both means of SUM_W quotient bits (SUM_W =
//   2*clog2(MAX_LEN) + FRAC_BITS, 28 by default) are produced by two
//   bit-serial dividers running side by side.
// Reset: window registers return to 10 / 1012, column state clears.
// Stall: the result sits in an output register; samples keep flowing into
//   the next column while it waits, and the next column's result, and with
//   it the input, holds off until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module interface_zero_crossing_locator #(
	parameter int MAX_LEN   = izcl_pkg::MAX_LEN_DEF,
	parameter int FRAC_BITS = izcl_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [izcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [izcl_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire izcl_pkg::in_beat_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output izcl_pkg::out_beat_t                 out_data
);

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CMP_W = (IDX_W > izcl_pkg::CFG_W) ? IDX_W : izcl_pkg::CFG_W;
	localparam int SUM_W = 2 * IDX_W + FRAC_BITS;
	localparam int SW    = izcl_pkg::SAMPLE_W;
	localparam int CW    = izcl_pkg::CNT_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LEN - 1);

	// window config
	logic [izcl_pkg::CFG_W-1:0] first_pair_q;
	logic [izcl_pkg::CFG_W-1:0] last_pair_q;

	// column state
	logic signed [SW-1:0] prev_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SUM_W-1:0]     rsum_q;
	logic [SUM_W-1:0]     fsum_q;
	logic [CW-1:0]        rtot_q;
	logic [CW-1:0]        ftot_q;

	// crossing in flight
	logic [IDX_W-1:0]     lo_q;
	logic                 rise_q;
	logic                 last_q;

	// counts held for the result while the means are divided
	logic [CW-1:0]        rhold_q;
	logic [CW-1:0]        fhold_q;

	izcl_pkg::state_t     state_q;
	izcl_pkg::state_t     state_n;

	izcl_pkg::out_beat_t  out_q;
	logic                 out_valid_q;

	// pair evaluation on the incoming beat
	logic                 in_acc;
	logic [IDX_W-1:0]     lo;
	logic [IDX_W-1:0]     idx_nxt;
	logic                 pair_ok;
	logic                 is_rise;
	logic                 is_fall;
	logic signed [SW:0]   p_x;
	logic signed [SW:0]   c_x;
	logic signed [SW:0]   num_x;
	logic signed [SW:0]   den_x;

	// sequencer strobes
	logic                 idiv_start;
	logic                 mdiv_start;
	logic                 out_load;

	// divider status
	logic                 idiv_busy;
	logic                 idiv_done;
	logic [FRAC_BITS-1:0] idiv_quot;
	logic                 rdiv_busy;
	logic                 rdiv_done;
	logic [SUM_W-1:0]     rdiv_quot;
	logic                 fdiv_busy;
	logic                 fdiv_done;
	logic [SUM_W-1:0]     fdiv_quot;

	always_comb begin
		in_acc  = in_valid && in_ready;
		lo      = idx_q - 1'b1;
		idx_nxt = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
		pair_ok = (idx_q != '0) &&
			(CMP_W'(lo) >= CMP_W'(first_pair_q)) &&
			(CMP_W'(lo) <= CMP_W'(last_pair_q));
		is_rise = pair_ok && (prev_q <= 0) && (in_data.sample > 0);
		is_fall = pair_ok && (prev_q >= 0) && (in_data.sample < 0);
		p_x     = {prev_q[SW-1], prev_q};
		c_x     = {in_data.sample[SW-1], in_data.sample};
		// num < den, den in 1..65535 for a valid crossing
		num_x   = is_rise ? -p_x : p_x;
		den_x   = is_rise ? (c_x - p_x) : (p_x - c_x);
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			izcl_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (is_rise || is_fall)
						state_n = izcl_pkg::ST_INTERP;
					else if (in_data.last)
						state_n = izcl_pkg::ST_MEAN_GO;
				end
			end
			izcl_pkg::ST_INTERP: begin
				if (idiv_done)
					state_n = last_q ? izcl_pkg::ST_MEAN_GO : izcl_pkg::ST_IDLE;
			end
			izcl_pkg::ST_MEAN_GO: begin
				state_n = izcl_pkg::ST_MEAN;
			end
			izcl_pkg::ST_MEAN: begin
				if (rdiv_done)
					state_n = izcl_pkg::ST_PUSH;
			end
			izcl_pkg::ST_PUSH: begin
				if (!out_valid_q || out_ready)
					state_n = izcl_pkg::ST_IDLE;
			end
			default: begin
				state_n = izcl_pkg::ST_IDLE;
			end
		endcase
	end

	// strobes
	always_comb begin
		in_ready   = 1'b0;
		idiv_start = 1'b0;
		mdiv_start = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			izcl_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				idiv_start = in_valid && (is_rise || is_fall);
			end
			izcl_pkg::ST_MEAN_GO: begin
				mdiv_start = 1'b1;
			end
			izcl_pkg::ST_PUSH: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= izcl_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pair_q <= izcl_pkg::FIRST_PAIR_RST;
			last_pair_q  <= izcl_pkg::LAST_PAIR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				izcl_pkg::REG_FIRST_PAIR: first_pair_q <= cfg_data;
				izcl_pkg::REG_LAST_PAIR:  last_pair_q  <= cfg_data;
				default: begin
					first_pair_q <= first_pair_q;
				end
			endcase
		end
	end

	// column state: sample history, index, sums and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			idx_q  <= '0;
			rsum_q <= '0;
			fsum_q <= '0;
			rtot_q <= '0;
			ftot_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (in_acc) begin
				last_q <= in_data.last;
				// end of column clears the history at once
				prev_q <= in_data.last ? '0 : in_data.sample;
				idx_q  <= in_data.last ? '0 : idx_nxt;
			end
			if (state_q == izcl_pkg::ST_INTERP && idiv_done) begin
				if (rise_q) begin
					rsum_q <= rsum_q + SUM_W'({lo_q, idiv_quot});
					if (rtot_q != izcl_pkg::CNT_MAX)
						rtot_q <= rtot_q + 1'b1;
				end else begin
					fsum_q <= fsum_q + SUM_W'({lo_q, idiv_quot});
					if (ftot_q != izcl_pkg::CNT_MAX)
						ftot_q <= ftot_q + 1'b1;
				end
			end
			if (mdiv_start) begin
				rsum_q <= '0;
				fsum_q <= '0;
				rtot_q <= '0;
				ftot_q <= '0;
			end
		end
	end

	// crossing and result payload
	always_ff @(posedge clk) begin
		if (idiv_start) begin
			lo_q   <= lo;
			rise_q <= is_rise;
		end
		if (mdiv_start) begin
			rhold_q <= rtot_q;
			fhold_q <= ftot_q;
		end
		if (out_load) begin
			out_q.rise_position <= (rhold_q != '0) ? izcl_pkg::POS_W'(rdiv_quot) : '0;
			out_q.fall_position <= (fhold_q != '0) ? izcl_pkg::POS_W'(fdiv_quot) : '0;
			out_q.rise_count    <= rhold_q;
			out_q.fall_count    <= fhold_q;
			out_q.rise_found    <= (rhold_q != '0);
			out_q.fall_found    <= (fhold_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// interpolation fraction: floor((num << FRAC_BITS) / den)
	izcl_sdiv #(
		.DVD_W (FRAC_BITS),
		.DVS_W (SW)
	) u_idiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (idiv_start),
		.rem_init (num_x[SW-1:0]),
		.dividend ('0),
		.divisor  (den_x[SW-1:0]),
		.busy     (idiv_busy),
		.done     (idiv_done),
		.quot     (idiv_quot)
	);

	// mean positions; a zero count gives junk that the found flag masks
	izcl_sdiv #(
		.DVD_W (SUM_W),
		.DVS_W (CW)
	) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mdiv_start),
		.rem_init ('0),
		.dividend (rsum_q),
		.divisor  (rtot_q),
		.busy     (rdiv_busy),
		.done     (rdiv_done),
		.quot     (rdiv_quot)
	);

	izcl_sdiv #(
		.DVD_W (SUM_W),
		.DVS_W (CW)
	) u_fdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mdiv_start),
		.rem_init ('0),
		.dividend (fsum_q),
		.divisor  (ftot_q),
		.busy     (fdiv_busy),
		.done     (fdiv_done),
		.quot     (fdiv_quot)
	);

	// checks
	a_idiv_free: assert property (@(posedge clk) disable iff (!arst_n)
		idiv_start |-> !idiv_busy)
		else $error("interpolation divider restarted while busy");

	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(is_rise && is_fall))
		else $error("pair flagged as both rising and falling");

	a_mean_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(rdiv_done == fdiv_done) && (rdiv_busy == fdiv_busy))
		else $error("mean dividers out of step");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.rise_found == (out_q.rise_count != '0)) &&
			(out_q.fall_found == (out_q.fall_count != '0)))
		else $error("found flag disagrees with count");

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(idiv_busy || rdiv_busy) |-> !in_ready)
		else $error("sample taken while a divider is working");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for interface_zero_crossing_locator. Sample beats go in
// one column at a time, and a behavioural copy of the crossing search predicts
// each column's means, counts and found flags. Every result beat is checked
// field by field against that prediction or a typed result. Short directed
// columns come first, then random columns across several window settings and
// idling modes, with a long receiver hold-off and a column long enough to wrap the index.
// ----------------------------------------------------------------------------

module testbench;

	localparam int STALL_LIMIT   = 4000; // cycles with no beat moving on either side
	localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
	localparam int SETTLE_CYCLES = 64;   // mean dividers plus a final interpolation
	localparam int PHASE_BEATS   = 100;
	localparam int SHORT_BEATS   = 12;   // short columns at the start of the hold-off
	localparam int WRAP_BEATS    = 1030; // > MAX_LEN, so the index wraps

	// one row of the directed table: either a register write or a sample beat
	typedef struct packed {
		logic                          is_cfg;
		logic                          typed;    // want holds a hand-written result
		izcl_pkg::cfg_reg_t            which;
		logic [izcl_pkg::CFG_W-1:0]    value;
		izcl_pkg::in_beat_t            beat;
		izcl_pkg::out_beat_t           want;
	} step_row_t;

	localparam izcl_pkg::out_beat_t NO_CROSSING = '0;
	// single crossing at lower index 0 with a zero fraction
	localparam izcl_pkg::out_beat_t ONE_RISE = '{rise_position: '0, fall_position: '0,
		rise_count: izcl_pkg::CNT_W'(1), fall_count: '0, rise_found: 1'b1,
		fall_found: 1'b0};
	localparam izcl_pkg::out_beat_t ONE_FALL = '{rise_position: '0, fall_position: '0,
		rise_count: '0, fall_count: izcl_pkg::CNT_W'(1), rise_found: 1'b0,
		fall_found: 1'b1};

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [izcl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [izcl_pkg::CFG_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	izcl_pkg::in_beat_t             in_data;
	logic                           out_valid;
	logic                           out_ready;
	izcl_pkg::out_beat_t            out_data;

	interface_zero_crossing_locator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// ------------------------------------------------------------------------
	// Crossing predictor: window registers plus the per-column state
	// ------------------------------------------------------------------------
	logic [izcl_pkg::CFG_W-1:0]           win_first;
	logic [izcl_pkg::CFG_W-1:0]           win_last;
	logic signed [izcl_pkg::SAMPLE_W-1:0] prev_sample;
	logic [9:0]                           next_index;  // wraps at 1024 on its own
	longint unsigned                      rise_acc;    // never wraps for any column we send
	longint unsigned                      fall_acc;
	logic [izcl_pkg::CNT_W-1:0]           rise_n;
	logic [izcl_pkg::CNT_W-1:0]           fall_n;

	izcl_pkg::out_beat_t pending_means[$];  // predicted column results, oldest first
	step_row_t directed_rows[$];

	int errors;
	int tx_idle_pct;
	int rx_idle_pct;
	logic hold_req;
	int hold_left;
	int quiet_cycles;
	izcl_pkg::out_beat_t oldest;

	task automatic restart_column();
		prev_sample = '0;
		next_index  = '0;
		rise_acc    = 0;
		fall_acc    = 0;
		rise_n      = '0;
		fall_n      = '0;
	endtask

	// floor((num << FRAC_BITS) / den); den is never zero on a crossing
	function automatic longint unsigned interp_frac(int unsigned num, int unsigned den);
		longint unsigned n;
		n = num;
		return (n << izcl_pkg::FRAC_BITS_DEF) / den;
	endfunction

	// Advances the predictor by one accepted beat; done is set on the beat
	// marked last, with the column's result in means.
	task automatic track_crossings(input izcl_pkg::in_beat_t b, output bit done,
		output izcl_pkg::out_beat_t means);
		int cur;
		int prv;
		int unsigned lo;
		longint unsigned base;
		cur   = $signed(b.sample);
		prv   = $signed(prev_sample);
		means = '0;
		// index 0 (column start, or after a wrap) has no lower neighbour
		if (next_index != 0) begin
			lo = next_index - 1;
			if (lo >= win_first && lo <= win_last) begin
				base = lo;
				base = base << izcl_pkg::FRAC_BITS_DEF;
				if (prv <= 0 && cur > 0) begin
					rise_acc += base + interp_frac(-prv, cur - prv);
					if (rise_n != izcl_pkg::CNT_MAX)
						rise_n++;
				end
				if (prv >= 0 && cur < 0) begin
					fall_acc += base + interp_frac(prv, prv - cur);
					if (fall_n != izcl_pkg::CNT_MAX)
						fall_n++;
				end
			end
		end
		prev_sample = b.sample;
		next_index  = next_index + 1'b1;
		done = b.last;
		if (done) begin
			means.rise_position = (rise_n != 0) ? izcl_pkg::POS_W'(rise_acc / rise_n) : '0;
			means.fall_position = (fall_n != 0) ? izcl_pkg::POS_W'(fall_acc / fall_n) : '0;
			means.rise_count    = rise_n;
			means.fall_count    = fall_n;
			means.rise_found    = (rise_n != 0);
			means.fall_found    = (fall_n != 0);
			restart_column();
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic step_row_t mk_beat(int smp, bit last, bit typed,
		izcl_pkg::out_beat_t want);
		step_row_t r;
		r = '0;
		r.beat.sample = izcl_pkg::SAMPLE_W'(smp);
		r.beat.last   = last;
		r.typed       = typed;
		r.want        = want;
		return r;
	endfunction

	function automatic step_row_t mk_cfg(izcl_pkg::cfg_reg_t which, int value);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.which  = which;
		r.value  = izcl_pkg::CFG_W'(value);
		return r;
	endfunction

	// Mostly small values around zero so that crossings are frequent, with
	// zeros, both extremes and full-range values mixed in.
	function automatic logic signed [izcl_pkg::SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(15))
			0:       v = 0;
			1:       v = -32768;
			2:       v = 32767;
			3, 4:    v = $urandom_range(65535);
			default: v = int'($urandom_range(600)) - 300;
		endcase
		return izcl_pkg::SAMPLE_W'(v);
	endfunction

	// Offers one beat after an optional random gap and returns at the edge
	// that accepts it. in_valid stays high, so the caller must either offer
	// the next beat or lower it within the same time step.
	task automatic push_sample(input izcl_pkg::in_beat_t b, input bit typed,
		input izcl_pkg::out_beat_t want);
		int gap;
		bit done;
		izcl_pkg::out_beat_t means;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_crossings(b, done, means);
		if (done)
			pending_means.push_back(typed ? want : means);
	endtask

	// Sender pauses until every predicted result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
	endtask

	// Window writes only go in once the block has gone quiet.
	task automatic write_reg(input izcl_pkg::cfg_reg_t which, input int value);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= izcl_pkg::CFG_W'(value);
		@(posedge clk);
		case (which)
			izcl_pkg::REG_FIRST_PAIR: win_first = izcl_pkg::CFG_W'(value);
			izcl_pkg::REG_LAST_PAIR:  win_last  = izcl_pkg::CFG_W'(value);
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Clock, receiver, checker, watchdog
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Receiver: random back-pressure, or a long hold-off counted here once
	// the main thread asks for one.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic compare_field(input string label,
		input logic [izcl_pkg::POS_W-1:0] want,
		input logic [izcl_pkg::POS_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_means.size() == 0) begin
				$display("%0t: result beat with none expected, got %p", $time, out_data);
				errors++;
			end else begin
				oldest = pending_means.pop_front();
				compare_field("rise_position", oldest.rise_position,
					out_data.rise_position);
				compare_field("fall_position", oldest.fall_position,
					out_data.fall_position);
				compare_field("rise_count", izcl_pkg::POS_W'(oldest.rise_count),
					izcl_pkg::POS_W'(out_data.rise_count));
				compare_field("fall_count", izcl_pkg::POS_W'(oldest.fall_count),
					izcl_pkg::POS_W'(out_data.fall_count));
				compare_field("rise_found", izcl_pkg::POS_W'(oldest.rise_found),
					izcl_pkg::POS_W'(out_data.rise_found));
				compare_field("fall_found", izcl_pkg::POS_W'(oldest.fall_found),
					izcl_pkg::POS_W'(out_data.fall_found));
			end
		end
	end

	// Watchdog: resets whenever a beat moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("interface_zero_crossing_locator: mismatch");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		izcl_pkg::in_beat_t b;
		int sent;
		int len;
		int lo_w;
		int hi_w;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b0;
		hold_req     = 1'b0;
		hold_left    = 0;
		quiet_cycles = 0;
		errors       = 0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		win_first    = izcl_pkg::FIRST_PAIR_RST;
		win_last     = izcl_pkg::LAST_PAIR_RST;
		restart_column();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Typed results are the ones obvious by inspection;
		// everything else goes through the predictor.
		// reset window 10..1012: a lone sample, then a pair at index 0 (outside)
		directed_rows.push_back(mk_beat(0, 1, 1, NO_CROSSING));
		directed_rows.push_back(mk_beat(-32768, 0, 0, '0));
		directed_rows.push_back(mk_beat(32767, 1, 1, NO_CROSSING));
		// widest window
		directed_rows.push_back(mk_cfg(izcl_pkg::REG_FIRST_PAIR, 0));
		directed_rows.push_back(mk_cfg(izcl_pkg::REG_LAST_PAIR, 1023));
		// zero to positive counts as a rise, zero to negative as a fall
		directed_rows.push_back(mk_beat(0, 0, 0, '0));
		directed_rows.push_back(mk_beat(8192, 1, 1, ONE_RISE));
		directed_rows.push_back(mk_beat(0, 0, 0, '0));
		directed_rows.push_back(mk_beat(-1, 1, 1, ONE_FALL));
		// full-scale swings: largest interpolation divisor
		directed_rows.push_back(mk_beat(-32768, 0, 0, '0));
		directed_rows.push_back(mk_beat(32767, 0, 0, '0));
		directed_rows.push_back(mk_beat(-32768, 1, 0, '0));
		// a zero run, then a fall with a zero fraction and a rise with a fraction
		directed_rows.push_back(mk_beat(100, 0, 0, '0));
		directed_rows.push_back(mk_beat(0, 0, 0, '0));
		directed_rows.push_back(mk_beat(0, 0, 0, '0));
		directed_rows.push_back(mk_beat(-5, 0, 0, '0));
		directed_rows.push_back(mk_beat(7, 1, 0, '0));
		// empty window: first above last
		directed_rows.push_back(mk_cfg(izcl_pkg::REG_FIRST_PAIR, 1023));
		directed_rows.push_back(mk_cfg(izcl_pkg::REG_LAST_PAIR, 0));
		directed_rows.push_back(mk_beat(-1, 0, 0, '0));
		directed_rows.push_back(mk_beat(1, 0, 0, '0));
		directed_rows.push_back(mk_beat(-1, 1, 1, NO_CROSSING));
		// window of a single pair
		directed_rows.push_back(mk_cfg(izcl_pkg::REG_FIRST_PAIR, 2));
		directed_rows.push_back(mk_cfg(izcl_pkg::REG_LAST_PAIR, 2));
		directed_rows.push_back(mk_beat(5, 0, 0, '0));
		directed_rows.push_back(mk_beat(-5, 0, 0, '0));
		directed_rows.push_back(mk_beat(5, 0, 0, '0));
		directed_rows.push_back(mk_beat(-5, 1, 0, '0));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_reg(directed_rows[i].which, directed_rows[i].value);
			else
				push_sample(directed_rows[i].beat, directed_rows[i].typed,
					directed_rows[i].want);
		end

		// Random columns: two phases per idling mode, a new window each phase.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin lo_w = 0; hi_w = 1023; end
				1: begin lo_w = $urandom_range(20); hi_w = lo_w + $urandom_range(40); end
				2: begin lo_w = $urandom_range(40); hi_w = $urandom_range(40); end
				3: begin lo_w = $urandom_range(10); hi_w = 1023; end
				4: begin lo_w = 0; hi_w = $urandom_range(50); end
				default: begin lo_w = $urandom_range(30); hi_w = lo_w; end
			endcase
			write_reg(izcl_pkg::REG_FIRST_PAIR, lo_w);
			write_reg(izcl_pkg::REG_LAST_PAIR, hi_w);
			tx_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 58 : 0;
			rx_idle_pct <= (ph < 2) ? 58 : (ph < 4) ? 38 : 0;
			// receiver holds off while short columns keep coming, so the
			// output register fills and the input stalls
			if (ph == 0)
				hold_req <= 1'b1;
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if (ph == 0 && sent < SHORT_BEATS)
					len = $urandom_range(3, 1);
				else if ($urandom_range(39) == 0)
					len = $urandom_range(300, 100);
				else
					len = $urandom_range(60, 1);
				for (int k = 0; k < len; k++) begin
					b.sample = pick_sample();
					b.last   = (k == len - 1);
					push_sample(b, 1'b0, '0);
				end
				sent += len;
				if ($urandom_range(24) == 0)
					drain();
			end
		end

		// One column past MAX_LEN with alternating signs: the index wraps
		// and the sample landing on index 0 forms no pair.
		write_reg(izcl_pkg::REG_FIRST_PAIR, 0);
		write_reg(izcl_pkg::REG_LAST_PAIR, 1023);
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		for (int k = 0; k < WRAP_BEATS; k++) begin
			if (k % 2 == 0)
				b.sample = izcl_pkg::SAMPLE_W'(-int'($urandom_range(32768, 1)));
			else
				b.sample = izcl_pkg::SAMPLE_W'($urandom_range(32767, 1));
			b.last = (k == WRAP_BEATS - 1);
			push_sample(b, 1'b0, '0);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_means.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_means.size());
			errors++;
		end
		if (errors == 0)
			$display("interface_zero_crossing_locator: match");
		else
			$display("interface_zero_crossing_locator: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/izcl_pkg.sv
rtl/izcl_sdiv.sv
rtl/interface_zero_crossing_locator.sv
dv/testbench.sv
